[hw/rtl/fuzzy_subsequence_scorer_unit_macros.svh]
// Assertion macros shared by the fuzzy subsequence scorer RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef FUZZY_SUBSEQUENCE_SCORER_UNIT_MACROS_SVH
`define FUZZY_SUBSEQUENCE_SCORER_UNIT_MACROS_SVH

// Plain property checked on every rising clock edge outside reset.
`define FSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication from an antecedent to a consequent in the following cycle.
`define FSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/fss_pkg.sv]
`timescale 1ns / 1ps
// Package for the fuzzy subsequence scorer: request codes, character
// constants, case folding and separator detection. No dependencies.
package fss_pkg;

  localparam int QUERY_MAX_DEF = 32;
  localparam int TEXT_MAX_DEF  = 4096;
  localparam int CHAR_W        = 16;
  localparam int SCORE_W       = 14;
  localparam int SCORE_MAX     = 8191;
  localparam int SCORE_MIN     = -8192;
  localparam int ADJ_BONUS     = 2;
  localparam int SEP_BONUS     = 3;
  localparam int TAIL_SHIFT    = 2;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2
  } op_e;

  localparam logic [CHAR_W-1:0] CH_SPACE     = 16'h0020;
  localparam logic [CHAR_W-1:0] CH_SLASH     = 16'h002F;
  localparam logic [CHAR_W-1:0] CH_BACKSLASH = 16'h005C;
  localparam logic [CHAR_W-1:0] CH_COLON     = 16'h003A;
  localparam logic [CHAR_W-1:0] CH_HYPHEN    = 16'h002D;
  localparam logic [CHAR_W-1:0] CH_UPPER_A   = 16'h0041;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z   = 16'h005A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 16'h0020;

  // Only the ASCII capitals fold to lower case.
  function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

  function automatic logic is_sep(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_SLASH) || (c == CH_BACKSLASH) ||
           (c == CH_COLON) || (c == CH_HYPHEN);
  endfunction

endpackage

[hw/rtl/fss_qram.sv]
`timescale 1ns / 1ps
// Query character store: one write port, one synchronous read port with
// write-to-read forwarding. Uses fss_pkg for the character width.
module fss_qram #(
  parameter int QueryMax = fss_pkg::QUERY_MAX_DEF,
  localparam int AddrW   = (QueryMax > 1) ? $clog2(QueryMax) : 1
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [fss_pkg::CHAR_W-1:0] wdata_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [fss_pkg::CHAR_W-1:0] rdata_o
);

  logic [fss_pkg::CHAR_W-1:0] mem_q [QueryMax];
  logic [fss_pkg::CHAR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // A write to the entry being read this cycle is passed straight through.
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/fuzzy_subsequence_scorer_unit.sv]
`timescale 1ns / 1ps
// Fuzzy subsequence scorer, top level. Depends on fss_pkg, fss_qram and the
// assertion macro header.
//
// Usage: every request on the input channel carries op_i, ch_i and last_i.
// A clear request empties the query and abandons any text in progress, an
// append request adds one case-folded character to the query, and a text
// request feeds one text character. A text request with last_i set ends the
// text and produces exactly one result on the output channel: matched_o,
// a signed 14-bit score_o (lower is better, zero when nothing matched) and
// overflow_o, which flags a text or query that ran past its bound.
// Throughput is one request per cycle in any mix of ops while the output
// is not stalled. The rate is held by the query store read loop: the store
// is read at the next match index every cycle, so its read latency is hidden.
// The result appears in the output register on the cycle after the final
// text request is accepted. While a result waits in the output register and
// the receiver stalls, the result holds there and in_stall_o follows
// out_stall_i, so every request waits, whatever its op.
// Reset empties the query and the text state; no clearing pass is needed.
`include "fuzzy_subsequence_scorer_unit_macros.svh"

module fuzzy_subsequence_scorer_unit #(
  parameter int QueryMax = fss_pkg::QUERY_MAX_DEF,
  parameter int TextMax  = fss_pkg::TEXT_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  op_i,
  input  logic [fss_pkg::CHAR_W-1:0]  ch_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        matched_o,
  output logic signed [fss_pkg::SCORE_W-1:0] score_o,
  output logic                        overflow_o
);

  localparam int AddrW = (QueryMax > 1) ? $clog2(QueryMax) : 1;
  localparam int QlW   = $clog2(QueryMax + 1);
  localparam int PosW  = $clog2(TextMax + 1);
  localparam int DifW  = (PosW > QlW) ? PosW : QlW;
  localparam int SumW  = ((PosW + 1 > fss_pkg::SCORE_W) ? PosW + 1 : fss_pkg::SCORE_W) + 2;
  localparam int ScW   = fss_pkg::SCORE_W;

  localparam logic [QlW-1:0]  QueryMaxC = QlW'(QueryMax);
  localparam logic [PosW-1:0] TextMaxC  = PosW'(TextMax);
  localparam logic signed [SumW-1:0] SatHi = SumW'(fss_pkg::SCORE_MAX);
  localparam logic signed [SumW-1:0] SatLo = SumW'(fss_pkg::SCORE_MIN);
  localparam logic signed [SumW-1:0] AdjC  = SumW'(fss_pkg::ADJ_BONUS);
  localparam logic signed [SumW-1:0] SepC  = SumW'(fss_pkg::SEP_BONUS);

  // Query side state.
  logic [QlW-1:0]  qlen_q, qlen_d;
  logic            qovf_q, qovf_d;
  // Text side state. gap_start always equals the last match position plus
  // one once a match exists, so it also serves the adjacency test.
  logic [QlW-1:0]  midx_q, midx_d;
  logic [PosW-1:0] tpos_q, tpos_d;
  logic [PosW-1:0] gap_q, gap_d;
  logic            lmv_q, lmv_d;
  logic signed [ScW-1:0] sum_q, sum_d;
  logic            psep_q, psep_d;
  logic            tovf_q, tovf_d;
  // Output register.
  logic            ovalid_q, ovalid_d;
  logic            omatch_q, omatch_d;
  logic signed [ScW-1:0] oscore_q, oscore_d;
  logic            oovf_q, oovf_d;

  // Query store ports.
  logic                       we;
  logic [AddrW-1:0]           waddr;
  logic [fss_pkg::CHAR_W-1:0] wdata;
  logic [AddrW-1:0]           raddr;
  logic [fss_pkg::CHAR_W-1:0] qchar;

  logic                       acc;
  logic [fss_pkg::CHAR_W-1:0] fch;
  logic                       hit;
  logic [PosW-1:0]            gap_len;
  logic signed [SumW-1:0]     step_raw;
  logic signed [ScW-1:0]      step_sum;
  logic [QlW-1:0]             end_midx;
  logic [PosW-1:0]            end_tpos;
  logic signed [ScW-1:0]      end_sum;
  logic                       end_tovf;
  logic [DifW-1:0]            tail_len;
  logic signed [SumW-1:0]     fin_raw;
  logic signed [ScW-1:0]      fin_sat;
  logic                       fin_match;

  assign acc        = in_valid_i && !in_stall_o;
  assign in_stall_o = ovalid_q && out_stall_i;

  fss_qram #(
    .QueryMax(QueryMax)
  ) u_qram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(qchar)
  );

  // The store always reads the entry at the next match index, so qchar
  // holds the query character that the current match index points at.
  assign raddr = (midx_d < QueryMaxC) ? midx_d[AddrW-1:0] : '0;
  assign waddr = qlen_q[AddrW-1:0];
  assign wdata = fss_pkg::fold(ch_i);

  // One text character: compare against the pending query character and
  // fold the gap and the bonuses into the running sum with saturation.
  assign fch      = fss_pkg::fold(ch_i);
  assign hit      = (midx_q < qlen_q) && (fch == qchar);
  assign gap_len  = tpos_q - gap_q;
  assign step_raw = SumW'(sum_q) + SumW'(gap_len)
                  - ((lmv_q && (gap_len == '0)) ? AdjC : '0)
                  - (psep_q ? SepC : '0);
  assign step_sum = (step_raw > SatHi) ? ScW'(SatHi) :
                    (step_raw < SatLo) ? ScW'(SatLo) : ScW'(step_raw);

  // Text state as it stands after this character, before any restart.
  always_comb begin
    end_midx = midx_q;
    end_tpos = tpos_q;
    end_sum  = sum_q;
    end_tovf = tovf_q;
    if (tpos_q < TextMaxC) begin
      end_tpos = tpos_q + PosW'(1);
      if (hit) begin
        end_midx = midx_q + QlW'(1);
        end_sum  = step_sum;
      end
    end else begin
      end_tovf = 1'b1;
    end
  end

  // Final score: a full match implies the text is at least as long as the
  // query, so the length difference is never negative here.
  assign fin_match = (end_midx == qlen_q);
  assign tail_len  = DifW'(end_tpos) - DifW'(qlen_q);
  assign fin_raw   = SumW'(end_sum) + SumW'(tail_len >> fss_pkg::TAIL_SHIFT);
  assign fin_sat   = (fin_raw > SatHi) ? ScW'(SatHi) :
                     (fin_raw < SatLo) ? ScW'(SatLo) : ScW'(fin_raw);

  always_comb begin
    qlen_d   = qlen_q;
    qovf_d   = qovf_q;
    midx_d   = midx_q;
    tpos_d   = tpos_q;
    gap_d    = gap_q;
    lmv_d    = lmv_q;
    sum_d    = sum_q;
    psep_d   = psep_q;
    tovf_d   = tovf_q;
    we       = 1'b0;
    ovalid_d = ovalid_q && out_stall_i;
    omatch_d = omatch_q;
    oscore_d = oscore_q;
    oovf_d   = oovf_q;

    if (acc) begin
      case (op_i)
        fss_pkg::OP_CLEAR: begin
          qlen_d = '0;
          qovf_d = 1'b0;
          midx_d = '0;
          tpos_d = '0;
          gap_d  = '0;
          lmv_d  = 1'b0;
          sum_d  = '0;
          psep_d = 1'b1;
          tovf_d = 1'b0;
        end
        fss_pkg::OP_APPEND: begin
          if (qlen_q < QueryMaxC) begin
            we     = 1'b1;
            qlen_d = qlen_q + QlW'(1);
          end else begin
            qovf_d = 1'b1;
          end
        end
        fss_pkg::OP_TEXT: begin
          midx_d = end_midx;
          tpos_d = end_tpos;
          sum_d  = end_sum;
          tovf_d = end_tovf;
          if (tpos_q < TextMaxC) begin
            psep_d = fss_pkg::is_sep(fch);
            if (hit) begin
              gap_d = tpos_q + PosW'(1);
              lmv_d = 1'b1;
            end
          end
          if (last_i) begin
            ovalid_d = 1'b1;
            omatch_d = (qlen_q == '0) || fin_match;
            oscore_d = ((qlen_q != '0) && fin_match) ? fin_sat : '0;
            oovf_d   = end_tovf || qovf_q;
            // The text side restarts once its result is captured.
            midx_d = '0;
            tpos_d = '0;
            gap_d  = '0;
            lmv_d  = 1'b0;
            sum_d  = '0;
            psep_d = 1'b1;
            tovf_d = 1'b0;
          end
        end
        default: begin
          // The unused code is accepted and changes nothing.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlen_q   <= '0;
      qovf_q   <= 1'b0;
      midx_q   <= '0;
      tpos_q   <= '0;
      gap_q    <= '0;
      lmv_q    <= 1'b0;
      sum_q    <= '0;
      psep_q   <= 1'b1;
      tovf_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      qlen_q   <= qlen_d;
      qovf_q   <= qovf_d;
      midx_q   <= midx_d;
      tpos_q   <= tpos_d;
      gap_q    <= gap_d;
      lmv_q    <= lmv_d;
      sum_q    <= sum_d;
      psep_q   <= psep_d;
      tovf_q   <= tovf_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    omatch_q <= omatch_d;
    oscore_q <= oscore_d;
    oovf_q   <= oovf_d;
  end

  assign out_valid_o = ovalid_q;
  assign matched_o   = omatch_q;
  assign score_o     = oscore_q;
  assign overflow_o  = oovf_q;

  // The match index can never run past the stored query.
  `FSS_ASSERT(a_midx_bound, midx_q <= qlen_q, "match index beyond query length")
  // Positions stay within the text bound, and the gap start never leads.
  `FSS_ASSERT(a_pos_bound, (tpos_q <= TextMaxC) && (gap_q <= tpos_q),
              "text position or gap start out of range")
  // A new result enters only from an accepted final text character.
  `FSS_ASSERT_NEXT(a_res_src, !(acc && (op_i == fss_pkg::OP_TEXT) && last_i) && !out_stall_i,
                   !ovalid_q, "result appeared without a final text character")
  // A captured result clears the text side for the next text.
  `FSS_ASSERT_NEXT(a_restart, acc && (op_i == fss_pkg::OP_TEXT) && last_i,
                   (tpos_q == '0) && (midx_q == '0) && psep_q && !tovf_q,
                   "text state not restarted after a result")

endmodule
